// ===== rtl/rawt_pkg.sv =====
// ----------------------------------------------------------------------------
// Reliable ack window tracker package
// Shared constants, codes and word types of the tracker.
// ----------------------------------------------------------------------------
package rawt_pkg;

  localparam int QUEUE_SLOTS  = 32;
  localparam int ACK_BITS     = 32;
  localparam int HEADER_BYTES = 10;
  localparam int MAX_OUT      = 32;
  localparam int SLOT_W       = $clog2(QUEUE_SLOTS);
  localparam int CNT_W        = $clog2(QUEUE_SLOTS + 1);
  localparam logic [15:0] NEWER_SPAN = 16'd32767;

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_RECV = 2'd1,
    OP_SCAN = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_SENT     = 3'd0,
    KIND_REJECT   = 3'd1,
    KIND_DELIVER  = 3'd2,
    KIND_NO_PAY   = 3'd3,
    KIND_DROP     = 3'd4,
    KIND_RESEND   = 3'd5,
    KIND_NOTHING  = 3'd6,
    KIND_UNUSED   = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    REG_PROTOCOL_ID = 2'd0,
    REG_RESEND_WIN  = 2'd1,
    REG_MAX_PAYLOAD = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] now_ms;
    logic [15:0] length_bytes;
    logic [31:0] rx_protocol;
    logic [15:0] rx_sequence;
    logic [15:0] rx_ack;
    logic [31:0] rx_ack_bits;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [15:0] sequence_res;
    logic [15:0] ack_out;
    logic [31:0] ack_bits_out;
    logic [4:0]  slot;
    logic [15:0] deliver_length;
    logic        last;
  } out_word_t;

  // Per-slot verdict of the shared evaluation unit.
  typedef struct packed {
    logic        due;
    logic        acked;
    logic [15:0] seq_age;
  } slot_eval_t;

endpackage

// ===== rtl/rawt_if.sv =====
// ----------------------------------------------------------------------------
// Reliable ack window tracker channels
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface rawt_in_if;
  logic               valid;
  logic               ready;
  rawt_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rawt_out_if;
  logic                valid;
  logic                ready;
  rawt_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/reliable_ack_window_tracker.sv =====
// ----------------------------------------------------------------------------
// Reliable ack window tracker
// Sequence numbering, ack bookkeeping and resend scheduling for a reliable
// datagram channel, one slot visited per cycle by a shared evaluation unit.
// ----------------------------------------------------------------------------
// Send: an oversized length goes straight to the result, else a slot search, one slot a cycle.
// Receive: a 32-slot ack sweep, window update, then the result; a dropped one goes straight to it.
// Scan: a counting sweep over all slots, then one selection sweep per resend word.
// One item at a time; a new item is taken once the last word is registered.
// Reset clears all control state and the valid bits; config regs reset.
module reliable_ack_window_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  rawt_in_if.sink     in_i,
  rawt_out_if.source  out_o
);
  import rawt_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(QUEUE_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_FIND, S_CLR, S_NOTE, S_COUNT, S_PASS, S_EMIT
  } state_e;

  state_e state_q;
  logic [SLOT_W-1:0] idx_q;
  logic [31:0] now_q;
  logic [15:0] len_q, rx_seq_q, ack_q;
  logic [31:0] bits_q;
  logic [QUEUE_SLOTS-1:0] valid_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic found_q;
  logic [SLOT_W-1:0] best_idx_q;
  logic [15:0] best_age_q, best_seq_q;
  logic [15:0] next_seq_q, newest_q;
  logic [31:0] field_q;
  logic [31:0] proto_id_q;
  logic [15:0] window_q, max_pay_q;
  kind_e kind_q;
  logic [15:0] pseq_q, pdlen_q;
  logic [SLOT_W-1:0] pslot_q;
  logic plast_q, ret_pass_q;
  logic out_valid_q;
  out_word_t out_q;

  logic [15:0] seq_mem [QUEUE_SLOTS];
  logic [31:0] time_mem [QUEUE_SLOTS];

  slot_eval_t ev;
  logic in_fire, cur_valid, elig, better;
  logic [SLOT_W-1:0] bidx_fin;
  logic [15:0] bseq_fin;
  logic wr_send, wr_stamp;
  logic emit_load;
  logic [CNT_W-1:0] cnt_nx;
  logic [15:0] d_fwd, d_back, d_back_m1, d_fwd_m1;

  rawt_slot_eval u_eval (
    .slot_seq_i  (seq_mem[idx_q]),
    .slot_time_i (time_mem[idx_q]),
    .now_i       (now_q),
    .window_i    (window_q),
    .next_seq_i  (next_seq_q),
    .ack_i       (ack_q),
    .ack_bits_i  (bits_q),
    .eval_o      (ev)
  );

  assign in_fire   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    cur_valid = valid_q[idx_q];
    elig      = cur_valid && !done_q[idx_q] && ev.due;
    better    = elig && (!found_q || (ev.seq_age > best_age_q));
    bidx_fin  = better ? idx_q : best_idx_q;
    bseq_fin  = better ? seq_mem[idx_q] : best_seq_q;
    wr_send   = (state_q == S_FIND) && !cur_valid;
    wr_stamp  = (state_q == S_PASS) && (idx_q == LAST_IDX);
    emit_load = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);
    cnt_nx    = cnt_q + CNT_W'(cur_valid && ev.due);
    d_fwd     = rx_seq_q - newest_q;
    d_fwd_m1  = d_fwd - 16'd1;
    d_back    = newest_q - rx_seq_q;
    d_back_m1 = d_back - 16'd1;
  end

  always_ff @(posedge clk_i) begin
    if (wr_send) begin
      seq_mem[idx_q]  <= next_seq_q;
      time_mem[idx_q] <= now_q;
    end
    if (wr_stamp) begin
      time_mem[bidx_fin] <= now_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proto_id_q  <= '0;
      window_q    <= 16'd100;
      max_pay_q   <= 16'd1200;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_PROTOCOL_ID: proto_id_q <= cfg_data_i;
        REG_RESEND_WIN:  window_q   <= cfg_data_i[15:0];
        REG_MAX_PAYLOAD: max_pay_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      valid_q     <= '0;
      done_q      <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      next_seq_q  <= '0;
      newest_q    <= '0;
      field_q     <= '0;
      ret_pass_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            now_q      <= in_i.data.now_ms;
            len_q      <= in_i.data.length_bytes;
            rx_seq_q   <= in_i.data.rx_sequence;
            ack_q      <= in_i.data.rx_ack;
            bits_q     <= in_i.data.rx_ack_bits;
            idx_q      <= '0;
            cnt_q      <= '0;
            done_q     <= '0;
            found_q    <= 1'b0;
            ret_pass_q <= 1'b0;
            pseq_q     <= '0;
            pslot_q    <= '0;
            pdlen_q    <= '0;
            plast_q    <= 1'b1;
            unique case (op_e'(in_i.data.operation))
              OP_SEND: begin
                if (in_i.data.length_bytes > max_pay_q) begin
                  kind_q  <= KIND_REJECT;
                  state_q <= S_EMIT;
                end else begin
                  state_q <= S_FIND;
                end
              end
              OP_RECV: begin
                if ((in_i.data.length_bytes < 16'(HEADER_BYTES)) ||
                    (in_i.data.rx_protocol != proto_id_q)) begin
                  kind_q  <= KIND_DROP;
                  state_q <= S_EMIT;
                end else begin
                  state_q <= S_CLR;
                end
              end
              OP_SCAN: state_q <= S_COUNT;
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_FIND: begin
          if (!cur_valid) begin
            valid_q[idx_q] <= 1'b1;
            kind_q     <= KIND_SENT;
            pseq_q     <= next_seq_q;
            pslot_q    <= idx_q;
            next_seq_q <= next_seq_q + 16'd1;
            state_q    <= S_EMIT;
          end else if (idx_q == LAST_IDX) begin
            kind_q  <= KIND_REJECT;
            state_q <= S_EMIT;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_CLR: begin
          if (cur_valid && ev.acked) begin
            valid_q[idx_q] <= 1'b0;
          end
          if (idx_q == LAST_IDX) begin
            state_q <= S_NOTE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_NOTE: begin
          if (d_fwd != 16'd0) begin
            if (d_fwd <= NEWER_SPAN) begin
              if (d_fwd < 16'(ACK_BITS)) begin
                field_q <= (field_q << d_fwd[4:0]) | (32'd1 << d_fwd_m1[4:0]);
              end else begin
                field_q <= '0;
              end
              newest_q <= rx_seq_q;
            end else if (d_back <= 16'(ACK_BITS)) begin
              field_q <= field_q | (32'd1 << d_back_m1[4:0]);
            end
          end
          if (len_q > 16'(HEADER_BYTES)) begin
            kind_q  <= KIND_DELIVER;
            pdlen_q <= len_q - 16'(HEADER_BYTES);
          end else begin
            kind_q <= KIND_NO_PAY;
          end
          state_q <= S_EMIT;
        end
        S_COUNT: begin
          cnt_q <= cnt_nx;
          if (idx_q == LAST_IDX) begin
            idx_q <= '0;
            if (cnt_nx == '0) begin
              kind_q  <= KIND_NOTHING;
              state_q <= S_EMIT;
            end else begin
              state_q <= S_PASS;
            end
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_PASS: begin
          if (better) begin
            found_q    <= 1'b1;
            best_idx_q <= idx_q;
            best_age_q <= ev.seq_age;
            best_seq_q <= seq_mem[idx_q];
          end
          if (idx_q == LAST_IDX) begin
            // The due count guarantees a candidate on every pass.
            done_q[bidx_fin] <= 1'b1;
            kind_q     <= KIND_RESEND;
            pseq_q     <= bseq_fin;
            pslot_q    <= bidx_fin;
            plast_q    <= (cnt_q == CNT_W'(1));
            ret_pass_q <= (cnt_q != CNT_W'(1));
            cnt_q      <= cnt_q - 1'b1;
            state_q    <= S_EMIT;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            out_q.result_kind    <= kind_q;
            out_q.sequence_res   <= pseq_q;
            out_q.ack_out        <= newest_q;
            out_q.ack_bits_out   <= field_q;
            out_q.slot           <= pslot_q;
            out_q.deliver_length <= pdlen_q;
            out_q.last           <= plast_q;
            idx_q   <= '0;
            found_q <= 1'b0;
            state_q <= ret_pass_q ? S_PASS : S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_send_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_send |-> !valid_q[idx_q]) else $error("send wrote an occupied slot");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_OUT)) else $error("resend count out of range");
  a_pass_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_stamp |-> (found_q || elig)) else $error("scan pass found no due slot");
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && (!out_valid_q || out_o.ready)) |=> out_valid_q)
    else $error("result word not registered");
`endif

endmodule

// ===== rtl/rawt_slot_eval.sv =====
// ----------------------------------------------------------------------------
// Slot evaluation unit
// Ages one table slot in time and in sequence and checks it against the
// remote ack window. Shared by every pass of the sequencer.
// ----------------------------------------------------------------------------
module rawt_slot_eval (
  input  logic [15:0]            slot_seq_i,
  input  logic [31:0]            slot_time_i,
  input  logic [31:0]            now_i,
  input  logic [15:0]            window_i,
  input  logic [15:0]            next_seq_i,
  input  logic [15:0]            ack_i,
  input  logic [31:0]            ack_bits_i,
  output rawt_pkg::slot_eval_t   eval_o
);
  import rawt_pkg::*;

  logic [31:0] time_age;
  logic [15:0] ack_age;
  logic [15:0] ack_age_m1;

  always_comb begin
    time_age   = now_i - slot_time_i;
    ack_age    = ack_i - slot_seq_i;
    ack_age_m1 = ack_age - 16'd1;
    eval_o.due     = time_age >= {16'd0, window_i};
    eval_o.seq_age = next_seq_i - slot_seq_i;
    eval_o.acked   = (ack_age == 16'd0) ||
                     ((ack_age <= 16'(ACK_BITS)) && ack_bits_i[ack_age_m1[4:0]]);
  end

endmodule

// ===== tb/rawt_tb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker testbench channel helpers
// Nothing beyond the RTL channel interfaces is needed; this file keeps the
// shared testbench types for the tracker bench.
// ----------------------------------------------------------------------------
package rawt_tb_pkg;
  import rawt_pkg::*;

  // One row of the directed table: the input word, and an optional
  // typed-in result kind for every word of the item (KIND_UNUSED means predictor only).
  typedef struct {
    in_word_t word;
    kind_e    known_kind;
  } dir_row_t;
endpackage

// ===== tb/reliable_ack_window_tracker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reliable ack window tracker testbench
// Drives send, receive, resend-scan and no-op words with random gaps on both
// channels, predicts every result word and compares field by field.
// ----------------------------------------------------------------------------
module reliable_ack_window_tracker_tb;
  import rawt_pkg::*;
  import rawt_tb_pkg::*;

  localparam int LIMIT = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = REG_NONE;
  logic [31:0] cfg_data_i = '0;

  rawt_in_if  in_ch ();
  rawt_out_if out_ch ();

  reliable_ack_window_tracker dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state.
  logic [31:0] m_proto;
  logic [15:0] m_window;
  logic [15:0] m_max_pay;
  logic [15:0] m_next_seq;
  logic [15:0] m_newest;
  logic [31:0] m_field;
  logic        m_valid [QUEUE_SLOTS];
  logic [15:0] m_seq [QUEUE_SLOTS];
  logic [31:0] m_stamp [QUEUE_SLOTS];

  out_word_t pending_results[$];
  kind_e     known_kinds[$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        resends_seen = 0;
  int        cycles = 0;
  bit        quiet = 1'b0;
  bit        hold_off = 1'b0;
  bit        hold_start = 1'b0;

  function automatic out_word_t make_word(kind_e k, logic [15:0] sq, logic [4:0] sl,
                                          logic [15:0] dl);
    out_word_t w;
    w.result_kind = k;
    w.sequence_res = sq;
    w.ack_out = m_newest;
    w.ack_bits_out = m_field;
    w.slot = sl;
    w.deliver_length = dl;
    w.last = 1'b0;
    return w;
  endfunction

  task automatic predict_tracker(input in_word_t w);
    out_word_t res[$];
    int free_slot;
    int best;
    logic [15:0] best_age, age, d;
    bit done [QUEUE_SLOTS];
    free_slot = -1;
    case (op_e'(w.operation))
      OP_SEND: begin
        for (int i = QUEUE_SLOTS - 1; i >= 0; i--)
          if (!m_valid[i]) free_slot = i;
        if (w.length_bytes > m_max_pay || free_slot < 0) begin
          res.insert(res.size(), make_word(KIND_REJECT, 0, 0, 0));
        end else begin
          m_valid[free_slot] = 1'b1;
          m_seq[free_slot] = m_next_seq;
          m_stamp[free_slot] = w.now_ms;
          res.insert(res.size(), make_word(KIND_SENT, m_next_seq, free_slot[4:0], 0));
          m_next_seq++;
        end
      end
      OP_RECV: begin
        if (w.length_bytes < HEADER_BYTES || w.rx_protocol != m_proto) begin
          res.insert(res.size(), make_word(KIND_DROP, 0, 0, 0));
        end else begin
          for (int i = 0; i < QUEUE_SLOTS; i++) begin
            if (m_valid[i]) begin
              age = w.rx_ack - m_seq[i];
              if (age == 0) m_valid[i] = 1'b0;
              else if (age <= ACK_BITS && w.rx_ack_bits[age - 1]) m_valid[i] = 1'b0;
            end
          end
          d = w.rx_sequence - m_newest;
          if (d != 0) begin
            if (d <= NEWER_SPAN) begin
              if (d < ACK_BITS) m_field = (m_field << d) | (32'd1 << (d - 1));
              else m_field = '0;
              m_newest = w.rx_sequence;
            end else begin
              age = m_newest - w.rx_sequence;
              if (age >= 1 && age <= ACK_BITS) m_field[age - 1] = 1'b1;
            end
          end
          if (w.length_bytes > HEADER_BYTES)
            res.insert(res.size(),
                       make_word(KIND_DELIVER, 0, 0, w.length_bytes - HEADER_BYTES));
          else
            res.insert(res.size(), make_word(KIND_NO_PAY, 0, 0, 0));
        end
      end
      OP_SCAN: begin
        foreach (done[i]) done[i] = 1'b0;
        while (res.size() < MAX_OUT) begin
          best = -1;
          best_age = 0;
          for (int i = 0; i < QUEUE_SLOTS; i++) begin
            if (m_valid[i] && !done[i] && (w.now_ms - m_stamp[i]) >= {16'd0, m_window}) begin
              age = m_next_seq - m_seq[i];
              if (best < 0 || age > best_age) begin
                best = i;
                best_age = age;
              end
            end
          end
          if (best < 0) break;
          done[best] = 1'b1;
          m_stamp[best] = w.now_ms;
          res.insert(res.size(), make_word(KIND_RESEND, m_seq[best], best[4:0], 0));
        end
        if (res.size() == 0) res.insert(0, make_word(KIND_NOTHING, 0, 0, 0));
      end
      default: ;
    endcase
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) pending_results.insert(pending_results.size(), res[i]);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_PROTOCOL_ID: m_proto = val;
      REG_RESEND_WIN:  m_window = val[15:0];
      REG_MAX_PAYLOAD: m_max_pay = val[15:0];
      default: ;
    endcase
  endtask

  // The word stays offered after acceptance until the next call replaces it
  // or a gap or drain withdraws it.
  task automatic drive_word(input in_word_t w, input kind_e known);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    if (op_e'(w.operation) != OP_NONE) known_kinds.insert(known_kinds.size(), known);
    predict_tracker(w);
  endtask

  // Waits for the block to go idle before touching its registers.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic in_word_t rand_word(int op_bias);
    in_word_t w;
    int pick;
    w.operation = OP_SEND;
    w.now_ms = $urandom();
    w.length_bytes = $urandom_range(0, 1500);
    w.rx_protocol = m_proto;
    w.rx_sequence = m_newest + $urandom_range(0, 70) - 35;
    w.rx_ack = m_next_seq - $urandom_range(0, 40);
    w.rx_ack_bits = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < op_bias) w.operation = OP_SEND;
    else if (pick < 80) w.operation = OP_RECV;
    else if (pick < 97) w.operation = OP_SCAN;
    else w.operation = OP_NONE;
    // Some noise: full-range fields, wrong protocol, short datagram.
    if ($urandom_range(0, 9) == 0) begin
      w.length_bytes = $urandom();
      w.rx_protocol = $urandom();
      w.rx_sequence = $urandom();
      w.rx_ack = $urandom();
    end
    if ($urandom_range(0, 19) == 0) w.length_bytes = $urandom_range(0, HEADER_BYTES);
    return w;
  endfunction

  // Result side: random stalls, one long hold-off, field-by-field compare.
  always @(posedge clk_i) begin
    out_word_t e;
    if (out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.data.result_kind == KIND_RESEND) resends_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", out_ch.data);
      end else begin
        e = pending_results.pop_front();
        if (e.result_kind == KIND_SENT || e.result_kind == KIND_REJECT ||
            e.result_kind == KIND_DROP || e.result_kind == KIND_DELIVER ||
            e.result_kind == KIND_NO_PAY || e.result_kind == KIND_NOTHING ||
            e.result_kind == KIND_RESEND) begin
          if (known_kinds.size() > 0 && known_kinds[0] != KIND_UNUSED &&
              out_ch.data.result_kind != known_kinds[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("kind %0d, table says %0d", out_ch.data.result_kind, known_kinds[0]);
          end
        end
        if (e.last && known_kinds.size() > 0) void'(known_kinds.pop_front());
        if (out_ch.data.result_kind != e.result_kind ||
            out_ch.data.sequence_res != e.sequence_res ||
            out_ch.data.ack_out != e.ack_out ||
            out_ch.data.ack_bits_out != e.ack_bits_out ||
            out_ch.data.slot != e.slot ||
            out_ch.data.deliver_length != e.deliver_length ||
            out_ch.data.last != e.last) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", e, out_ch.data);
        end
      end
    end
  end

  int stall_left = 0;
  int hold_cnt = 0;
  always @(posedge clk_i) begin
    if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else if (quiet) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 18) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Long receiver hold-off, counted here while the sender keeps offering.
  initial begin
    wait (hold_start);
    hold_off = 1'b1;
    hold_cnt = 0;
    while (hold_cnt < 600) begin
      @(posedge clk_i);
      hold_cnt++;
    end
    hold_off = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  dir_row_t dir_rows[$];

  function automatic dir_row_t row(op_e op, logic [31:0] now, logic [15:0] len,
                                   logic [31:0] proto, logic [15:0] sq, logic [15:0] ack,
                                   logic [31:0] bits, kind_e k);
    dir_row_t r;
    r.word = '{op, now, len, proto, sq, ack, bits};
    r.known_kind = k;
    return r;
  endfunction

  task automatic queue_row(input dir_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endtask

  initial begin
    in_word_t w;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    m_proto = '0;
    m_window = 16'd100;
    m_max_pay = 16'd1200;
    m_next_seq = '0;
    m_newest = '0;
    m_field = '0;
    foreach (m_valid[i]) begin
      m_valid[i] = 1'b0;
      m_seq[i] = '0;
      m_stamp[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset settings.
    queue_row(row(OP_SCAN, 32'd0, 0, 0, 0, 0, 0, KIND_NOTHING));
    queue_row(row(OP_SEND, 32'd0, 16'd1201, 0, 0, 0, 0, KIND_REJECT));
    queue_row(row(OP_SEND, 32'd0, 16'hFFFF, 0, 0, 0, 0, KIND_REJECT));
    queue_row(row(OP_SEND, 32'd0, 16'd1200, 0, 0, 0, 0, KIND_SENT));
    queue_row(row(OP_SEND, 32'hFFFF_FFF0, 16'd0, 0, 0, 0, 0, KIND_SENT));
    queue_row(row(OP_SEND, 32'd5, 16'd10, 0, 0, 0, 0, KIND_SENT));
    queue_row(row(OP_RECV, 0, 16'd9, 0, 1, 0, 0, KIND_DROP));
    queue_row(row(OP_RECV, 0, 16'hFFFF, 32'hFFFF_FFFF, 1, 0, 0, KIND_DROP));
    queue_row(row(OP_RECV, 0, 16'd10, 0, 0, 16'hFFFF, 0, KIND_NO_PAY));
    queue_row(row(OP_RECV, 0, 16'hFFFF, 0, 16'd1, 16'd0, 32'd0, KIND_UNUSED));
    queue_row(row(OP_RECV, 0, 16'd11, 0, 16'd33, 16'd5, 32'hFFFF_FFFF, KIND_UNUSED));
    queue_row(row(OP_RECV, 0, 16'd11, 0, 16'd1, 0, 0, KIND_UNUSED));
    queue_row(row(OP_RECV, 0, 16'd11, 0, 16'd65, 0, 0, KIND_UNUSED));
    queue_row(row(OP_RECV, 0, 16'd11, 0, 16'd32833, 0, 0, KIND_UNUSED));
    queue_row(row(OP_RECV, 0, 16'd11, 0, 16'd32832, 0, 0, KIND_UNUSED));
    queue_row(row(OP_RECV, 0, 16'd11, 0, 16'd32832, 0, 0, KIND_UNUSED));
    queue_row(row(OP_RECV, 0, 16'd11, 0, 16'd32800, 0, 0, KIND_UNUSED));
    queue_row(row(OP_SEND, 32'd50, 16'd1, 0, 0, 0, 0, KIND_SENT));
    queue_row(row(OP_SEND, 32'd60, 16'd1, 0, 0, 0, 0, KIND_SENT));
    queue_row(row(OP_SCAN, 32'd99, 0, 0, 0, 0, 0, KIND_UNUSED));
    queue_row(row(OP_SCAN, 32'd40, 0, 0, 0, 0, 0, KIND_UNUSED));
    queue_row(row(OP_SCAN, 32'd40, 0, 0, 0, 0, 0, KIND_NOTHING));
    queue_row(row(OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
                  16'hFFFF, 32'hFFFF_FFFF, KIND_UNUSED));
    foreach (dir_rows[i]) drive_word(dir_rows[i].word, dir_rows[i].known_kind);
    drain();

    // Extremes of the registers, then fill the table to the cap.
    write_reg(REG_PROTOCOL_ID, 32'hFFFF_FFFF);
    write_reg(REG_RESEND_WIN, 16'd0);
    write_reg(REG_MAX_PAYLOAD, 16'hFFFF);
    for (int i = 0; i < 34; i++) begin
      w = rand_word(100);
      w.operation = OP_SEND;
      w.length_bytes = (i == 0) ? 16'hFFFF : $urandom();
      drive_word(w, KIND_UNUSED);
    end
    // With a zero window every slot is due: a full 32-word scan.
    w = rand_word(0);
    w.operation = OP_SCAN;
    drive_word(w, KIND_UNUSED);
    w.rx_protocol = 32'hFFFF_FFFF;
    w.operation = OP_RECV;
    w.length_bytes = 16'd10;
    w.rx_ack = m_next_seq - 1;
    w.rx_ack_bits = 32'hFFFF_FFFF;
    drive_word(w, KIND_NO_PAY);
    drain();

    write_reg(REG_PROTOCOL_ID, 32'h1234_5678);
    write_reg(REG_RESEND_WIN, 16'hFFFF);
    write_reg(REG_MAX_PAYLOAD, 16'd0);
    for (int i = 0; i < 20; i++) drive_word(rand_word(30), KIND_UNUSED);
    drain();

    // Pressure: the receiver holds off while scans and sends keep coming.
    write_reg(REG_RESEND_WIN, 16'd0);
    write_reg(REG_MAX_PAYLOAD, 16'd1000);
    hold_start = 1'b1;
    for (int i = 0; i < 8; i++) begin
      w = rand_word(0);
      w.operation = (i % 2) ? OP_SCAN : OP_SEND;
      w.length_bytes = 16'd3;
      drive_word(w, KIND_UNUSED);
    end
    drain();

    // Random traffic at assorted windows.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_RESEND_WIN, $urandom_range(0, 3000));
      write_reg(REG_PROTOCOL_ID, $urandom());
      for (int i = 0; i < 20; i++) begin
        if (ph == 3 && i > 8) quiet = 1'b1;
        w = rand_word(45);
        w.now_ms = 32'hFFFF_F000 + i * 200 + ph * 7000;
        drive_word(w, KIND_UNUSED);
      end
      drain();
    end

    $display("covered %0d result words, %0d of them resends, over %0d cycles",
             results_seen, resends_seen, cycles);
    $display("sends, receives with ack clearing, scans and register extremes exercised");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/rawt_pkg.sv
rtl/rawt_if.sv
rtl/rawt_slot_eval.sv
rtl/reliable_ack_window_tracker.sv
tb/rawt_tb_if.sv
tb/reliable_ack_window_tracker_tb.sv
